[hdl/float_to_q1_31_depth_convert_defines.svh]
// Assertion macros for the checker file.
`ifndef FLOAT_TO_Q1_31_DEPTH_CONVERT_DEFINES_SVH
`define FLOAT_TO_Q1_31_DEPTH_CONVERT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define F2Q_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication checked in the following cycle.
`define F2Q_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

[hdl/f2q_pkg.sv]
// ----------------------------------------------------------------------------
// f2q_pkg
// Shared constants and types for the float to 1.31 converter.
// ----------------------------------------------------------------------------
`default_nettype none
package f2q_pkg;
  localparam int unsigned DataW = 32;
  localparam logic [31:0] FixMax = 32'h7FFF_FFFF;
  localparam logic        OpDepth  = 1'b0;
  localparam logic        OpSigned = 1'b1;

  // Classification of one item after the first stage.
  typedef struct packed {
    logic       sat_pos;  // force +max
    logic       sat_neg;  // force -max
    logic       zero;     // force zero
    logic       neg;      // negate magnitude
  } cls_t;
endpackage
`default_nettype wire

[hdl/float_to_q1_31_depth_convert.sv]
// ----------------------------------------------------------------------------
// float_to_q1_31_depth_convert
// Float32 to saturating 1.31 fixed point, depth or signed mode.
// ----------------------------------------------------------------------------
// Three-stage pipeline: decode and classify, align and round, then sign and
// saturation select. One item enters per cycle while in_ready is high. A stall
// on the output halts the output stage and each full stage right behind it;
// stages that hold no item still take new ones.
`default_nettype none
module float_to_q1_31_depth_convert (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [f2q_pkg::DataW-1:0]     in_float_bits,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [f2q_pkg::DataW-1:0]   out_fixed_value
);
  f2q_pkg::cls_t cls_c, cls1_r, cls2_r;
  logic [23:0] sig_c, sig1_r;
  logic [5:0]  rsh_c, rsh1_r;
  logic [7:0]  lsh_c, lsh1_r;
  logic [31:0] mag_c, mag2_r;
  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;
  logic [31:0] res_c;

  f2q_classify u_cls (
    .op(in_op), .float_bits(in_float_bits[31:0]),
    .cls(cls_c), .sig(sig_c), .rsh(rsh_c)
  );
  assign lsh_c = in_float_bits[30:23] - 8'd119;

  f2q_round u_rnd (.sig(sig1_r), .lsh(lsh1_r), .rsh(rsh1_r), .mag(mag_c));

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    if (cls2_r.sat_pos) res_c = f2q_pkg::FixMax;
    else if (cls2_r.sat_neg) res_c = 32'd0 - f2q_pkg::FixMax;
    else if (cls2_r.zero) res_c = '0;
    else if (cls2_r.neg) res_c = 32'd0 - mag2_r;
    else res_c = mag2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) begin
      cls1_r <= cls_c;
      sig1_r <= sig_c;
      rsh1_r <= rsh_c;
      lsh1_r <= lsh_c;
    end
    if (en2) begin
      cls2_r <= cls1_r;
      mag2_r <= mag_c;
    end
    if (en3) out_fixed_value <= res_c;
  end

  assign out_valid = v3_r;
endmodule
`default_nettype wire

[hdl/f2q_classify.sv]
// ----------------------------------------------------------------------------
// f2q_classify
// Decodes the float fields, sorts out special cases and builds the shift.
// ----------------------------------------------------------------------------
`default_nettype none
module f2q_classify (
  input  wire logic        op,
  input  wire logic [31:0] float_bits,
  output f2q_pkg::cls_t    cls,
  output logic [23:0]      sig,
  output logic [5:0]       rsh      // right shift, 0..32 (32 means all gone)
);
  logic       s;
  logic [7:0] e;
  logic [22:0] m;
  logic       nan;
  logic       ge_one;
  logic [7:0] eff;
  logic [7:0] r;

  always_comb begin
    s = float_bits[31];
    e = float_bits[30:23];
    m = float_bits[22:0];
    nan = (e == 8'hFF) && (m != '0);
    ge_one = (e >= 8'd127);
    sig = (e == '0) ? {1'b0, m} : {1'b1, m};
    eff = (e == '0) ? 8'd1 : e;
    // Only exponents below 127 reach the datapath, so the left shift never
    // exceeds seven bits; right shifts of 32 or more give zero.
    r = 8'd119 - eff;
    rsh = 6'd0;
    if (eff < 8'd119) begin
      rsh = (r >= 8'd32) ? 6'd32 : r[5:0];
    end
    cls = '0;
    if (op == f2q_pkg::OpDepth) begin
      if (nan || (!s && ge_one)) cls.sat_pos = 1'b1;
      else if (s) cls.zero = 1'b1;
    end else begin
      if (nan) cls.zero = 1'b1;
      else if (ge_one) begin
        cls.sat_pos = !s;
        cls.sat_neg = s;
      end else cls.neg = s;
    end
  end
endmodule
`default_nettype wire

[hdl/f2q_round.sv]
// ----------------------------------------------------------------------------
// f2q_round
// Aligns the significand and rounds half to even to a 32-bit magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module f2q_round (
  input  wire logic [23:0] sig,
  input  wire logic [7:0]  lsh,
  input  wire logic [5:0]  rsh,
  output logic [31:0]      mag
);
  logic [63:0] ext;
  logic [63:0] shifted;
  logic [31:0] keep;
  logic        half_bit;
  logic        sticky;
  logic [31:0] low_mask;

  always_comb begin
    // Value is placed with 32 fraction bits below the integer part.
    ext = {8'd0, sig, 32'd0};
    if (rsh != '0) shifted = ext >> rsh;
    else shifted = ext << lsh[2:0];
    keep = shifted[63:32];
    half_bit = shifted[31];
    low_mask = 32'h7FFF_FFFF;
    sticky = |(shifted[31:0] & low_mask);
    mag = keep + {31'd0, half_bit && (sticky || keep[0])};
  end
endmodule
`default_nettype wire

[hdl/f2q_checker.sv]
// ----------------------------------------------------------------------------
// f2q_checker
// Port-level checks for the float to 1.31 converter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "float_to_q1_31_depth_convert_defines.svh"
module f2q_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_fixed_value
);
  // The pipeline must keep taking items whenever the output side drains.
  `F2Q_ASSERT_IMPL(a_ready_when_drain, clk, rst_n, out_ready, in_ready, "stalled with sink ready")
  // The value most negative is never produced.
  `F2Q_ASSERT_IMPL(a_no_min, clk, rst_n, out_valid, out_fixed_value != 32'h8000_0000, "min value out")
  // A stalled result holds its value.
  `F2Q_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_fixed_value), "held result changed")
  // With the sink ready throughout, an accepted item comes out as a valid result.
  `F2Q_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready, out_valid, "result missing")
endmodule
bind float_to_q1_31_depth_convert f2q_checker u_f2q_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_fixed_value(out_fixed_value)
);
`default_nettype wire

[sim/float_to_q1_31_depth_convert_tb.sv]
// ----------------------------------------------------------------------------
// float_to_q1_31_depth_convert_tb
// Regression for the float to 1.31 converter: directed corner values in both
// modes, then random items under several idle and stall patterns, with each
// result checked against a bit-exact predictor in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module float_to_q1_31_depth_convert_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency = 3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_op;
  logic [31:0] in_float_bits;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_fixed_value;

  logic [31:0] fixed_queue[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit long_hold;

  float_to_q1_31_depth_convert dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_float_bits(in_float_bits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_fixed_value(out_fixed_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Magnitude of |value| * 2^31, rounded half to even, for |value| < 1.0.
  function automatic logic [31:0] scale_magnitude(logic [7:0] expo, logic [22:0] mant);
    logic [23:0] sig;
    int unsigned eff;
    int unsigned rsh;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] half;
    sig = (expo == 8'd0) ? {1'b0, mant} : {1'b1, mant};
    eff = (expo == 8'd0) ? 1 : expo;
    if (sig == 24'd0) return 32'd0;
    if (eff >= 119) return 32'(64'(sig) << (eff - 119));
    rsh = 119 - eff;
    if (rsh >= 32) return 32'd0;
    mag = 64'(sig) >> rsh;
    rem = 64'(sig) & ((64'd1 << rsh) - 64'd1);
    half = 64'd1 << (rsh - 1);
    if (rem > half || (rem == half && mag[0])) mag = mag + 64'd1;
    return mag[31:0];
  endfunction

  function automatic logic [31:0] convert_fixed(logic op, logic [31:0] fbits);
    logic sgn;
    logic [7:0] expo;
    logic [22:0] mant;
    logic is_nan;
    logic ge_one;
    logic [31:0] mag;
    sgn = fbits[31];
    expo = fbits[30:23];
    mant = fbits[22:0];
    is_nan = (expo == 8'hFF) && (mant != 23'd0);
    ge_one = (expo >= 8'd127);
    if (op == f2q_pkg::OpDepth) begin
      if (is_nan) return f2q_pkg::FixMax;
      if (!sgn && ge_one) return f2q_pkg::FixMax;
      if (sgn || (expo == 8'd0 && mant == 23'd0)) return 32'd0;
      return scale_magnitude(expo, mant);
    end
    if (is_nan) return 32'd0;
    if (ge_one) return sgn ? (32'd0 - f2q_pkg::FixMax) : f2q_pkg::FixMax;
    mag = scale_magnitude(expo, mant);
    return sgn ? (32'd0 - mag) : mag;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Valid drops only while idling, so back-to-back items keep it high.
  task automatic send_item(logic op, logic [31:0] fbits);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_float_bits <= fbits;
    fixed_queue.push_back(convert_fixed(op, fbits));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (fixed_queue.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  // Receiver side and result check.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (fixed_queue.size() == 0) begin
          report_mismatch("unexpected result", out_fixed_value, 32'd0);
        end else begin
          if (out_fixed_value !== fixed_queue[0])
            report_mismatch("fixed_value", out_fixed_value, fixed_queue[0]);
          void'(fixed_queue.pop_front());
        end
      end
      out_ready <= !long_hold &&
        (recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("float_to_q1_31_depth_convert regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] corners[$];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                32'h3F80_0000, 32'hBF80_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                32'h3F00_0000, 32'h3380_0000, 32'h3000_0000, 32'h3080_0000};
    foreach (corners[i]) begin
      send_item(f2q_pkg::OpDepth, corners[i]);
      send_item(f2q_pkg::OpSigned, corners[i]);
    end
    wait_drained();
  endtask

  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    logic [31:0] fbits;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      fbits = $urandom();
      // Most items sit in the open interval (-1, 1) where rounding matters.
      if ($urandom_range(3) != 0) fbits[30:23] = 8'($urandom_range(126, 90));
      send_item(1'($urandom()), fbits);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 1'b1;
    fork
      begin
        repeat (40) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (20) send_item(1'($urandom()), $urandom());
    join
    wait_drained();
    repeat (10) send_item(1'($urandom()), $urandom());
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= 1'b0;
    in_float_bits <= '0;
    out_ready <= 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 59, 0);
    test_random(500, 0, 59);
    test_random(500, 38, 38);
    test_backpressure();
    if (mismatch_count == 0) $display("float_to_q1_31_depth_convert regression: pass");
    else $display("float_to_q1_31_depth_convert regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
